// ----- src/trms_pkg.sv -----
// Shared constants, types and codes of the two-range median select block.
package trms_pkg;

  localparam int DEPTH_DEFAULT       = 131072;
  localparam int VALUE_WIDTH_DEFAULT = 32;
  localparam int INDEX_W             = 17;
  localparam int IN_VALUE_W          = 32;
  // Signed width of index arithmetic; holds every address that four 17-bit indices can form.
  localparam int ADDR_SW             = 24;
  localparam int QUEUE_DEPTH         = 4;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef logic signed [ADDR_SW-1:0] saddr_t;

  // One job handed from the front to the back. A load uses addr0 and rd0_ok
  // (index inside the array) only.
  typedef struct packed {
    logic   is_query;
    logic   two_reads;
    logic   rd0_ok;
    logic   rd1_ok;
    saddr_t addr0;
    saddr_t addr1;
  } job_t;

endpackage

// ----- src/trms_if.sv -----
// Request and result channel interfaces of the two-range median select block.
interface trms_in_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  op;
  logic [trms_pkg::INDEX_W-1:0]          index;
  logic signed [trms_pkg::IN_VALUE_W-1:0] value;
  logic [trms_pkg::INDEX_W-1:0]          first_low;
  logic [trms_pkg::INDEX_W-1:0]          first_high;
  logic [trms_pkg::INDEX_W-1:0]          second_low;
  logic [trms_pkg::INDEX_W-1:0]          second_high;

  modport source (
    output valid, op, index, value, first_low, first_high, second_low, second_high,
    input  ready
  );
  modport sink (
    input  valid, op, index, value, first_low, first_high, second_low, second_high,
    output ready
  );
endinterface

interface trms_out_if #(
  parameter int W = trms_pkg::VALUE_WIDTH_DEFAULT + 1
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] median_x2;

  modport source (output valid, median_x2, input ready);
  modport sink   (input valid, median_x2, output ready);
endinterface

// ----- src/trms_ram.sv -----
// Generic single-port RAM with registered read data.
module trms_ram #(
  parameter  int WIDTH = 32,
  parameter  int DEPTH = 2,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             en,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem_r[addr] <= wdata;
      end else begin
        rdata_r <= mem_r[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- src/trms_queue.sv -----
// Short job queue between the front and the back.
module trms_queue #(
  parameter  int VALUE_WIDTH = trms_pkg::VALUE_WIDTH_DEFAULT,
  parameter  int DEPTH       = trms_pkg::QUEUE_DEPTH,
  localparam int PW          = $clog2(DEPTH),
  localparam int CW          = $clog2(DEPTH + 1)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push_valid,
  output logic                   push_ready,
  input  trms_pkg::job_t         push_job,
  input  logic [VALUE_WIDTH-1:0] push_val,
  output logic                   pop_valid,
  input  logic                   pop_ready,
  output trms_pkg::job_t         pop_job,
  output logic [VALUE_WIDTH-1:0] pop_val
);

  trms_pkg::job_t         job_r [DEPTH];
  logic [VALUE_WIDTH-1:0] val_r [DEPTH];
  logic [PW-1:0]          wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]          rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]          count_r, count_nxt;
  logic                   do_push, do_pop;

  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_job    = job_r[rd_ptr_r];
  assign pop_val    = val_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? PW'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? PW'(rd_ptr_r + 1'b1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = CW'(count_r + 1'b1);
    end else if (do_pop && !do_push) begin
      count_nxt = CW'(count_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      job_r[wr_ptr_r] <= push_job;
      val_r[wr_ptr_r] <= push_val;
    end
  end

endmodule

// ----- src/trms_front.sv -----
// Front: accept requests, order the ranges and turn a query into read addresses.
module trms_front #(
  parameter int DEPTH       = trms_pkg::DEPTH_DEFAULT,
  parameter int VALUE_WIDTH = trms_pkg::VALUE_WIDTH_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst_n,
  trms_in_if.sink                in_ch,
  output logic                   push_valid,
  input  logic                   push_ready,
  output trms_pkg::job_t         push_job,
  output logic [VALUE_WIDTH-1:0] push_val
);

  typedef trms_pkg::saddr_t saddr_t;

  // Address of the k-th (1-based) element of the union; lo1 <= lo2.
  function automatic saddr_t kth_addr(
    input saddr_t k,
    input logic   disj,
    input saddr_t lo1,
    input saddr_t lo2,
    input saddr_t hmin,
    input saddr_t a_dis,
    input saddr_t a_ov,
    input saddr_t ab2
  );
    saddr_t t;
    saddr_t h;
    saddr_t r;
    t = k - a_ov + saddr_t'(1);
    h = (t < 0) ? ((t + saddr_t'(1)) >>> 1) : (t >>> 1);
    if (disj) begin
      r = (k > a_dis) ? (lo2 + k - a_dis - saddr_t'(1)) : (lo1 + k - saddr_t'(1));
    end else if (k <= a_ov) begin
      r = lo1 + k - saddr_t'(1);
    end else if (k <= ab2) begin
      r = lo2 + h - saddr_t'(1);
    end else begin
      r = hmin + k - ab2;
    end
    return r;
  endfunction

  function automatic logic in_array(input saddr_t a);
    return (a >= 0) && (a < saddr_t'(DEPTH));
  endfunction

  logic adv;

  // Stage 1: ordered ranges and total count
  logic                   s1_valid_r;
  logic                   s1_query_r;
  saddr_t                 s1_ld_addr_r;
  logic                   s1_ld_ok_r;
  logic [VALUE_WIDTH-1:0] s1_val_r;
  saddr_t                 s1_lo1_r, s1_hi1_r, s1_lo2_r, s1_hi2_r, s1_len_r;

  saddr_t f_lo, f_hi, s_lo, s_hi, ld_addr;
  logic   swap;

  // Stage 2: split points and middle ranks
  logic                   s2_valid_r;
  logic                   s2_query_r;
  saddr_t                 s2_ld_addr_r;
  logic                   s2_ld_ok_r;
  logic [VALUE_WIDTH-1:0] s2_val_r;
  logic                   s2_disj_r, s2_even_r;
  saddr_t                 s2_lo1_r, s2_lo2_r, s2_hmin_r;
  saddr_t                 s2_a_dis_r, s2_a_ov_r, s2_ab2_r, s2_k1_r, s2_k2_r;

  saddr_t hmin, b_ov, k1, a1, a2;

  assign adv         = !s2_valid_r || push_ready;
  assign in_ch.ready = adv;

  assign f_lo    = saddr_t'(in_ch.first_low);
  assign f_hi    = saddr_t'(in_ch.first_high);
  assign s_lo    = saddr_t'(in_ch.second_low);
  assign s_hi    = saddr_t'(in_ch.second_high);
  assign ld_addr = saddr_t'(in_ch.index);
  assign swap    = s_lo < f_lo;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_ch.valid;
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_ch.valid) begin
      s1_query_r   <= (in_ch.op == trms_pkg::OP_QUERY);
      s1_ld_addr_r <= ld_addr;
      s1_ld_ok_r   <= in_array(ld_addr);
      s1_val_r     <= VALUE_WIDTH'(in_ch.value);
      s1_lo1_r     <= swap ? s_lo : f_lo;
      s1_hi1_r     <= swap ? s_hi : f_hi;
      s1_lo2_r     <= swap ? f_lo : s_lo;
      s1_hi2_r     <= swap ? f_hi : s_hi;
      s1_len_r     <= (f_hi - f_lo + saddr_t'(1)) + (s_hi - s_lo + saddr_t'(1));
    end
  end

  assign hmin = (s1_hi1_r < s1_hi2_r) ? s1_hi1_r : s1_hi2_r;
  assign b_ov = hmin - s1_lo2_r + saddr_t'(1);
  // halve toward zero
  assign k1   = (s1_len_r < 0) ? ((s1_len_r + saddr_t'(1)) >>> 1) : (s1_len_r >>> 1);

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_query_r   <= s1_query_r;
      s2_ld_addr_r <= s1_ld_addr_r;
      s2_ld_ok_r   <= s1_ld_ok_r;
      s2_val_r     <= s1_val_r;
      s2_disj_r    <= s1_lo2_r > s1_hi1_r;
      s2_even_r    <= !s1_len_r[0];
      s2_lo1_r     <= s1_lo1_r;
      s2_lo2_r     <= s1_lo2_r;
      s2_hmin_r    <= hmin;
      s2_a_dis_r   <= s1_hi1_r - s1_lo1_r + saddr_t'(1);
      s2_a_ov_r    <= s1_lo2_r - s1_lo1_r;
      s2_ab2_r     <= (s1_lo2_r - s1_lo1_r) + (b_ov <<< 1);
      s2_k1_r      <= k1;
      s2_k2_r      <= k1 + saddr_t'(1);
    end
  end

  assign a1 = kth_addr(s2_k1_r, s2_disj_r, s2_lo1_r, s2_lo2_r, s2_hmin_r,
                       s2_a_dis_r, s2_a_ov_r, s2_ab2_r);
  assign a2 = kth_addr(s2_k2_r, s2_disj_r, s2_lo1_r, s2_lo2_r, s2_hmin_r,
                       s2_a_dis_r, s2_a_ov_r, s2_ab2_r);

  always_comb begin
    push_job = '0;
    if (s2_query_r) begin
      push_job.is_query  = 1'b1;
      push_job.two_reads = s2_even_r;
      push_job.addr0     = s2_even_r ? a1 : a2;
      push_job.rd0_ok    = in_array(s2_even_r ? a1 : a2);
      push_job.addr1     = a2;
      push_job.rd1_ok    = in_array(a2);
    end else begin
      push_job.addr0  = s2_ld_addr_r;
      push_job.rd0_ok = s2_ld_ok_r;
    end
  end

  assign push_valid = s2_valid_r;
  assign push_val   = s2_val_r;

endmodule

// ----- src/trms_back.sv -----
// Back: run jobs against the element memory and form the doubled median.
module trms_back #(
  parameter  int DEPTH       = trms_pkg::DEPTH_DEFAULT,
  parameter  int VALUE_WIDTH = trms_pkg::VALUE_WIDTH_DEFAULT,
  localparam int AW          = $clog2(DEPTH)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   pop_valid,
  output logic                   pop_ready,
  input  trms_pkg::job_t         pop_job,
  input  logic [VALUE_WIDTH-1:0] pop_val,
  trms_out_if.source             out_ch
);

  localparam logic ST_ISSUE  = 1'b0;
  localparam logic ST_SECOND = 1'b1;

  logic                          state_r, state_nxt;
  logic                          fin_r, fin_nxt;
  logic                          fin_odd_r, fin_odd_nxt;
  logic                          fin_ok_r, fin_ok_nxt;
  trms_pkg::job_t                cur_r;
  logic signed [VALUE_WIDTH-1:0] e0_r;
  logic                          out_valid_r;
  logic signed [VALUE_WIDTH:0]   out_data_r;

  logic                          stall, do_pop, rd0, rd1;
  logic                          ram_en, ram_we;
  logic [AW-1:0]                 ram_addr;
  logic [VALUE_WIDTH-1:0]        ram_rdata;
  logic signed [VALUE_WIDTH-1:0] elem;
  logic signed [VALUE_WIDTH:0]   sum;

  // Hold everything while a finished sum cannot enter the output register.
  assign stall     = fin_r && out_valid_r && !out_ch.ready;
  assign pop_ready = (state_r == ST_ISSUE) && !stall;
  assign do_pop    = pop_valid && pop_ready;
  assign rd0       = do_pop && pop_job.is_query;
  assign rd1       = (state_r == ST_SECOND) && !stall;
  assign ram_we    = do_pop && !pop_job.is_query && pop_job.rd0_ok;
  assign ram_en    = ram_we || rd0 || rd1;
  assign ram_addr  = rd1 ? AW'(cur_r.addr1) : AW'(pop_job.addr0);

  trms_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (DEPTH)
  ) u_mem (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (pop_val),
    .rdata (ram_rdata)
  );

  assign elem = fin_ok_r ? $signed(ram_rdata) : '0;
  assign sum  = fin_odd_r ? ({elem[VALUE_WIDTH-1], elem} + {elem[VALUE_WIDTH-1], elem})
                          : ({e0_r[VALUE_WIDTH-1], e0_r} + {elem[VALUE_WIDTH-1], elem});

  always_comb begin
    state_nxt   = state_r;
    fin_nxt     = fin_r;
    fin_odd_nxt = fin_odd_r;
    fin_ok_nxt  = fin_ok_r;
    if (!stall) begin
      fin_nxt = 1'b0;
      unique case (state_r)
        ST_ISSUE: begin
          if (rd0) begin
            if (pop_job.two_reads) begin
              state_nxt = ST_SECOND;
            end else begin
              fin_nxt     = 1'b1;
              fin_odd_nxt = 1'b1;
              fin_ok_nxt  = pop_job.rd0_ok;
            end
          end
        end
        ST_SECOND: begin
          state_nxt   = ST_ISSUE;
          fin_nxt     = 1'b1;
          fin_odd_nxt = 1'b0;
          fin_ok_nxt  = cur_r.rd1_ok;
        end
        default: state_nxt = ST_ISSUE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_ISSUE;
      fin_r       <= 1'b0;
      fin_odd_r   <= 1'b0;
      fin_ok_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      fin_r     <= fin_nxt;
      fin_odd_r <= fin_odd_nxt;
      fin_ok_r  <= fin_ok_nxt;
      if (fin_r && !stall) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_pop) begin
      cur_r <= pop_job;
    end
    if (rd1) begin
      e0_r <= cur_r.rd0_ok ? $signed(ram_rdata) : '0;
    end
    if (fin_r && !stall) begin
      out_data_r <= sum;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.median_x2 = out_data_r;

endmodule

// ----- src/two_range_median_select_top.sv -----
// Top level of the two-range median select block.
//
// Usage: the request channel in_ch carries two kinds of request. A load
// (op = load) writes value into the sorted element memory at index; an index
// at or beyond DEPTH is dropped. A query (op = query) names two inclusive
// index ranges and returns one result on out_ch: median_x2, the sum of the
// two middle elements of the union of both ranges (overlap counted twice),
// i.e. twice the median with one fraction bit. Loads return nothing.
// A query result passes the front stages, the queue, the memory read and the
// output register, and may wait in the queue; an even total count adds a second read.
// Throughput: the single memory port sets the pace; an even-count query takes
// two reads in the back end, an odd-count query one read and a load one write.
// The front takes one request per cycle while its queue has room.
// Reset (rst_n low, synchronous) clears all control state; memory contents
// are undefined until written and are not cleared.
// When out_ch stalls, the finished result holds in the output register, the
// back end halts before overwriting it, the queue fills and in_ch.ready drops.
module two_range_median_select_top #(
  parameter int DEPTH       = trms_pkg::DEPTH_DEFAULT,
  parameter int VALUE_WIDTH = trms_pkg::VALUE_WIDTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst_n,
  trms_in_if.sink    in_ch,
  trms_out_if.source out_ch
);

  // queue hookup between front and back
  logic                   q_push_valid, q_push_ready;
  trms_pkg::job_t         q_push_job;
  logic [VALUE_WIDTH-1:0] q_push_val;
  logic                   q_pop_valid, q_pop_ready;
  trms_pkg::job_t         q_pop_job;
  logic [VALUE_WIDTH-1:0] q_pop_val;

  // Order the ranges and work out read addresses.
  trms_front #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_job   (q_push_job),
    .push_val   (q_push_val)
  );

  // Decouple the front from memory stalls and output back-pressure.
  trms_queue #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .DEPTH       (trms_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_job   (q_push_job),
    .push_val   (q_push_val),
    .pop_valid  (q_pop_valid),
    .pop_ready  (q_pop_ready),
    .pop_job    (q_pop_job),
    .pop_val    (q_pop_val)
  );

  // Write loads, read the middle elements and sum them.
  trms_back #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (q_pop_valid),
    .pop_ready (q_pop_ready),
    .pop_job   (q_pop_job),
    .pop_val   (q_pop_val),
    .out_ch    (out_ch)
  );

endmodule

// ----- sim/tb.sv -----
// Testbench for two_range_median_select_top: directed and random requests against a predictor.
module tb;

  localparam int DEPTH        = trms_pkg::DEPTH_DEFAULT;
  localparam int VW           = trms_pkg::VALUE_WIDTH_DEFAULT;
  localparam int OW           = VW + 1;
  localparam int IW           = trms_pkg::INDEX_W;
  localparam int CLK_PERIOD   = 20;
  localparam int RESET_CYCLES = 9;
  // Written windows at both ends of the array; queries stay inside them.
  localparam int REGION       = 48;
  localparam int HOLD_CYCLES  = 60;
  localparam int PHASE_ITEMS  = 95;
  localparam int DRAIN_CYCLES = 20;
  localparam int REPORT_LIMIT = 10;
  localparam int LIMIT_CYCLES = 400000;

  // Idle percentages per phase: none, sender only, receiver only, both.
  localparam int SEND_IDLE [4] = '{0, 62, 0, 21};
  localparam int RECV_STALL[4] = '{0, 0, 62, 21};

  localparam logic signed [VW-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [VW-1:0] VAL_MAX = 32'sh7FFF_FFFF;

  typedef logic signed [OW-1:0] med_t;
  typedef logic signed [VW-1:0] elem_t;
  typedef logic [IW-1:0]        idx_t;

  // One request as offered on in_ch; fixed/want carry a hand-typed answer.
  typedef struct packed {
    logic                                   op;
    idx_t                                   index;
    logic signed [trms_pkg::IN_VALUE_W-1:0] value;
    idx_t                                   first_low;
    idx_t                                   first_high;
    idx_t                                   second_low;
    idx_t                                   second_high;
    logic                                   fixed;
    med_t                                   want;
  } req_t;

  logic clk;
  logic rst_n;

  trms_in_if              in_ch ();
  trms_out_if #(.W(OW))   out_ch ();

  two_range_median_select_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Predictor state: element contents as seen at request acceptance.
  elem_t elem_mem [int];
  // Shadow of which entries will have been written, tracked at generation time
  // so that no query ever reads an entry that was never loaded.
  bit    gen_written [DEPTH];

  req_t  send_q [$];
  req_t  dir_rows [$];
  med_t  median_due [$];

  int    requests_queued = 0;
  int    requests_taken  = 0;
  int    mismatches      = 0;
  int    send_idle_pct   = 0;
  int    recv_stall_pct  = 0;
  int    hold_asked      = 0;

  initial clk = 1'b0;
  always #(CLK_PERIOD / 2) clk = ~clk;

  // Run limit, far above the slowest legal run.
  initial begin
    #(CLK_PERIOD * LIMIT_CYCLES);
    $display("simulation failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Address of the k-th (1-based) element of the union; lo1 <= lo2 already.
  // Disjoint ranges: plain concatenation. Overlapping ranges: head of the
  // earlier range, then the shared part with each entry counted twice, then
  // the tail past the smaller end.
  function automatic longint kth_addr(input longint k, input longint lo1, input longint hi1,
                                      input longint lo2, input longint hi2);
    longint a, b, hmin;
    if (lo2 > hi1) begin
      a = hi1 - lo1 + 1;
      if (k > a) return lo2 + k - a - 1;
      return lo1 + k - 1;
    end
    hmin = (hi1 < hi2) ? hi1 : hi2;
    a    = lo2 - lo1;
    b    = hmin - lo2 + 1;
    if (k <= a) return lo1 + k - 1;
    // Integer division truncates toward zero, also for inverted ranges.
    if (k <= a + 2 * b) return lo2 + (k - a + 1) / 2 - 1;
    return hmin + k - a - 2 * b;
  endfunction

  // Both middle addresses of a query; an odd count reads one entry twice.
  function automatic void median_addrs(input req_t r, output longint ad0, output longint ad1);
    longint lo1, hi1, lo2, hi2, len, t;
    lo1 = longint'(r.first_low);
    hi1 = longint'(r.first_high);
    lo2 = longint'(r.second_low);
    hi2 = longint'(r.second_high);
    len = (hi1 - lo1 + 1) + (hi2 - lo2 + 1);
    // Order the ranges by start.
    if (lo2 < lo1) begin
      t = lo1; lo1 = lo2; lo2 = t;
      t = hi1; hi1 = hi2; hi2 = t;
    end
    if (len[0]) begin
      ad0 = kth_addr(len / 2 + 1, lo1, hi1, lo2, hi2);
      ad1 = ad0;
    end else begin
      ad0 = kth_addr(len / 2, lo1, hi1, lo2, hi2);
      ad1 = kth_addr(len / 2 + 1, lo1, hi1, lo2, hi2);
    end
  endfunction

  // Addresses outside the array read as zero.
  function automatic elem_t read_elem(input longint ad);
    if (ad < 0 || ad >= DEPTH) return '0;
    if (elem_mem.exists(int'(ad))) return elem_mem[int'(ad)];
    return '0;
  endfunction

  function automatic med_t median_x2_of(input req_t r);
    longint a0, a1;
    med_t   e0, e1;
    median_addrs(r, a0, a1);
    e0 = med_t'(read_elem(a0));
    e1 = med_t'(read_elem(a1));
    return e0 + e1;
  endfunction

  function automatic bit slot_loaded(input longint ad);
    return ad < 0 || ad >= DEPTH || gen_written[int'(ad)];
  endfunction

  function automatic bit reads_written(input req_t r);
    longint a0, a1;
    median_addrs(r, a0, a1);
    return slot_loaded(a0) && slot_loaded(a1);
  endfunction

  // ---------------------------------------------------------------------------
  // Request builders; fields a request ignores carry random junk.
  // ---------------------------------------------------------------------------

  function automatic req_t load_req(input int idx, input elem_t val);
    req_t r;
    r.op          = trms_pkg::OP_LOAD;
    r.index       = idx_t'(idx);
    r.value       = val;
    r.first_low   = idx_t'($urandom);
    r.first_high  = idx_t'($urandom);
    r.second_low  = idx_t'($urandom);
    r.second_high = idx_t'($urandom);
    r.fixed       = 1'b0;
    r.want        = '0;
    return r;
  endfunction

  function automatic req_t query_req(input int fl, input int fh, input int sl, input int sh);
    req_t r;
    r.op          = trms_pkg::OP_QUERY;
    r.index       = idx_t'($urandom);
    r.value       = $urandom;
    r.first_low   = idx_t'(fl);
    r.first_high  = idx_t'(fh);
    r.second_low  = idx_t'(sl);
    r.second_high = idx_t'(sh);
    r.fixed       = 1'b0;
    r.want        = '0;
    return r;
  endfunction

  function automatic req_t with_answer(input req_t r, input med_t w);
    r.fixed = 1'b1;
    r.want  = w;
    return r;
  endfunction

  function automatic int rand_slot();
    if ($urandom_range(1)) return DEPTH - REGION + $urandom_range(REGION - 1);
    return $urandom_range(REGION - 1);
  endfunction

  // Well-formed range inside one written window.
  function automatic void rand_range(output int lo, output int hi);
    int base, x, y;
    base = $urandom_range(1) ? DEPTH - REGION : 0;
    x    = base + $urandom_range(REGION - 1);
    y    = base + $urandom_range(REGION - 1);
    lo   = (x < y) ? x : y;
    hi   = (x < y) ? y : x;
  endfunction

  // Random query; a broken one swaps one range's ends or draws all four ends from either
  // window. Retry up to 40 times until every read lands on a loaded entry or off the array.
  function automatic req_t random_query(input bit broken);
    req_t r;
    int   fl, fh, sl, sh, t;
    for (int tries = 0; tries < 40; tries++) begin
      rand_range(fl, fh);
      rand_range(sl, sh);
      if (broken) begin
        case ($urandom_range(2))
          0: begin t = fl; fl = fh; fh = t; end
          1: begin t = sl; sl = sh; sh = t; end
          default: begin
            fl = rand_slot(); fh = rand_slot();
            sl = rand_slot(); sh = rand_slot();
          end
        endcase
      end
      r = query_req(fl, fh, sl, sh);
      if (reads_written(r)) return r;
    end
    rand_range(fl, fh);
    rand_range(sl, sh);
    return query_req(fl, fh, sl, sh);
  endfunction

  task automatic queue_request(input req_t r);
    send_q.push_back(r);
    requests_queued++;
    if (r.op == trms_pkg::OP_LOAD && r.index < DEPTH) gen_written[r.index] = 1'b1;
  endtask

  task automatic wait_accepted();
    while (requests_taken != requests_queued) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Request side: offer queued requests, hold each until accepted, idle at
  // random. Update the predictor on every accepted request.
  // ---------------------------------------------------------------------------
  initial begin
    req_t cur;
    cur               = '0;
    in_ch.valid       <= 1'b0;
    in_ch.op          <= trms_pkg::OP_LOAD;
    in_ch.index       <= '0;
    in_ch.value       <= '0;
    in_ch.first_low   <= '0;
    in_ch.first_high  <= '0;
    in_ch.second_low  <= '0;
    in_ch.second_high <= '0;
    forever begin
      @(posedge clk);
      if (!rst_n) begin
        in_ch.valid <= 1'b0;
      end else begin
        if (in_ch.valid && in_ch.ready) begin
          requests_taken++;
          if (cur.op == trms_pkg::OP_LOAD) begin
            // Drop loads past the end of the array.
            if (cur.index < DEPTH) elem_mem[int'(cur.index)] = cur.value;
          end else begin
            median_due.push_back(cur.fixed ? cur.want : median_x2_of(cur));
          end
        end
        // Advance only when the bus is free or the last request was taken.
        if (!in_ch.valid || in_ch.ready) begin
          if (send_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            cur                = send_q.pop_front();
            in_ch.valid       <= 1'b1;
            in_ch.op          <= cur.op;
            in_ch.index       <= cur.index;
            in_ch.value       <= cur.value;
            in_ch.first_low   <= cur.first_low;
            in_ch.first_high  <= cur.first_high;
            in_ch.second_low  <= cur.second_low;
            in_ch.second_high <= cur.second_high;
          end else begin
            in_ch.valid <= 1'b0;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result side: compare each accepted result with the oldest expectation,
  // stall at random, and hold off for a long stretch when asked.
  // ---------------------------------------------------------------------------
  initial begin
    int   hold_seen;
    int   hold_left;
    med_t want;
    hold_seen    = 0;
    hold_left    = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst_n) begin
        out_ch.ready <= 1'b0;
      end else begin
        if (out_ch.valid && out_ch.ready) begin
          if (median_due.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
              $display("median_x2 %0d arrived with no query outstanding", out_ch.median_x2);
          end else begin
            want = median_due.pop_front();
            if (out_ch.median_x2 !== want) begin
              mismatches++;
              if (mismatches <= REPORT_LIMIT)
                $display("median_x2 mismatch: expected %0d, actual %0d",
                         want, out_ch.median_x2);
            end
          end
        end
        if (hold_asked != hold_seen) begin
          hold_seen = hold_asked;
          hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
          hold_left--;
          out_ch.ready <= 1'b0;
        end else begin
          out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int roll;
    int v;
    rst_n <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table: extremes of the element range at both ends of the array,
    // a handful of sorted entries near index zero, then queries covering
    // disjoint, swapped, nested, partial and identical ranges, plus inverted
    // ranges (empty ranges, negative counts, reads off the array).
    dir_rows.push_back(load_req(0, VAL_MIN));
    dir_rows.push_back(load_req(1, -5));
    dir_rows.push_back(load_req(2, 0));
    dir_rows.push_back(load_req(3, 7));
    dir_rows.push_back(load_req(4, 1000));
    dir_rows.push_back(load_req(DEPTH - 2, VAL_MAX - 1));
    dir_rows.push_back(load_req(DEPTH - 1, VAL_MAX));
    // Twice the minimum, twice the maximum, minimum plus maximum.
    dir_rows.push_back(with_answer(query_req(0, 0, 0, 0), 33'h1_0000_0000));
    dir_rows.push_back(with_answer(query_req(DEPTH - 1, DEPTH - 1, DEPTH - 1, DEPTH - 1),
                                   33'h0_FFFF_FFFE));
    dir_rows.push_back(with_answer(query_req(0, 0, DEPTH - 1, DEPTH - 1), 33'h1_FFFF_FFFF));
    dir_rows.push_back(query_req(0, 1, 2, 4));
    dir_rows.push_back(query_req(2, 4, 0, 1));
    dir_rows.push_back(query_req(0, 3, 1, 2));
    dir_rows.push_back(query_req(1, 3, 2, 4));
    dir_rows.push_back(query_req(0, 4, 0, 4));
    dir_rows.push_back(query_req(DEPTH - 2, DEPTH - 1, 0, 0));
    dir_rows.push_back(query_req(3, 3, 0, 4));
    dir_rows.push_back(query_req(1, 0, 0, 0));
    dir_rows.push_back(query_req(0, 0, 2, 0));
    dir_rows.push_back(query_req(DEPTH - 1, 0, DEPTH - 1, 0));
    dir_rows.push_back(query_req(4, 2, 1, 3));
    dir_rows.push_back(query_req(DEPTH - 1, DEPTH - 1, DEPTH - 1, DEPTH - 2));
    foreach (dir_rows[i]) queue_request(dir_rows[i]);
    wait_accepted();

    // Random part in four idle phases.
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct  = SEND_IDLE[phase];
      recv_stall_pct = RECV_STALL[phase];
      if (phase == 0) begin
        // Fill both windows with non-decreasing contents.
        v = int'(VAL_MIN) + $urandom_range(0, 1 << 20);
        for (int i = 0; i < REGION; i++) begin
          queue_request(load_req(i, v));
          v += $urandom_range(0, 1 << 20);
        end
        v = (1 << 30) + $urandom_range(0, 1 << 20);
        for (int i = DEPTH - REGION; i < DEPTH; i++) begin
          queue_request(load_req(i, v));
          v += $urandom_range(0, 1 << 20);
        end
        wait_accepted();
        // Starve the result side so the block backs up and stalls in_ch.
        hold_asked++;
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        roll = $urandom_range(99);
        if (roll < 15) queue_request(load_req(rand_slot(), $urandom));
        else if (roll < 27) queue_request(random_query(1'b1));
        else queue_request(random_query(1'b0));
      end
      wait_accepted();
    end

    // Drain outstanding results, then allow the block's latency to pass.
    while (median_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
